// ----- rtl/core/mck_pkg.sv -----
// Shared types, constants and the Morse pattern table for the character keyer.
// No dependencies; every other file of the keyer but mck_ram refers to it by scoped names.
package mck_pkg;

    localparam int NumRegs = 5;
    localparam int RegAw   = 3;
    localparam int DurW    = 8;
    localparam int CharW   = 8;
    localparam int PatW    = 8;
    localparam int IdxW    = 6;
    localparam int PaddrW  = 5;
    localparam int ApbDw   = 32;

    localparam logic [CharW-1:0] CharSpace = 8'h20;
    localparam logic [CharW-1:0] CharFirst = 8'h30;
    localparam logic [CharW-1:0] CharLast  = 8'h5A;
    localparam logic [CharW-1:0] CharQuery = 8'h3F;

    // Register file layout
    typedef enum logic [RegAw-1:0] {
        REG_DOT        = 3'd0,
        REG_DASH       = 3'd1,
        REG_ELEM_GAP   = 3'd2,
        REG_LETTER_GAP = 3'd3,
        REG_WORD_GAP   = 3'd4
    } t_reg;

    // Element request from the sequencer to the output stage
    typedef struct packed {
        logic tone;
        logic last;
        t_reg reg_sel;
    } t_req;

    // One keying element as delivered
    typedef struct packed {
        logic            tone;
        logic [DurW-1:0] dur;
        logic            last;
    } t_elem;

    // Value a register holds until first written
    function automatic logic [DurW-1:0] reg_reset(input t_reg r);
        logic [DurW-1:0] v;
        v = '0;
        unique case (r)
            REG_DOT:        v = 8'd1;
            REG_DASH:       v = 8'd3;
            REG_ELEM_GAP:   v = 8'd1;
            REG_LETTER_GAP: v = 8'd3;
            REG_WORD_GAP:   v = 8'd7;
            default:        v = '0;
        endcase
        return v;
    endfunction

    // Pattern per character from '0': LSB first, 1 is a dash, top set bit ends it
    function automatic logic [PatW-1:0] code_pattern(input logic [IdxW-1:0] idx);
        logic [PatW-1:0] p;
        p = '0;
        unique case (idx)
            6'd0:  p = 8'h3f;  6'd1:  p = 8'h3e;  6'd2:  p = 8'h3c;  6'd3:  p = 8'h38;
            6'd4:  p = 8'h30;  6'd5:  p = 8'h20;  6'd6:  p = 8'h21;  6'd7:  p = 8'h23;
            6'd8:  p = 8'h27;  6'd9:  p = 8'h2f;  6'd10: p = 8'h47;  6'd11: p = 8'h55;
            6'd12: p = 8'h2d;  6'd13: p = 8'h31;  6'd14: p = 8'h6d;  6'd15: p = 8'h4c;
            6'd16: p = 8'h56;  6'd17: p = 8'h06;  6'd18: p = 8'h11;  6'd19: p = 8'h15;
            6'd20: p = 8'h09;  6'd21: p = 8'h02;  6'd22: p = 8'h14;  6'd23: p = 8'h0b;
            6'd24: p = 8'h10;  6'd25: p = 8'h04;  6'd26: p = 8'h1e;  6'd27: p = 8'h0d;
            6'd28: p = 8'h12;  6'd29: p = 8'h07;  6'd30: p = 8'h05;  6'd31: p = 8'h0f;
            6'd32: p = 8'h16;  6'd33: p = 8'h1b;  6'd34: p = 8'h0a;  6'd35: p = 8'h08;
            6'd36: p = 8'h03;  6'd37: p = 8'h0c;  6'd38: p = 8'h18;  6'd39: p = 8'h0e;
            6'd40: p = 8'h19;  6'd41: p = 8'h1d;  6'd42: p = 8'h13;
            default: p = 8'h4c;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/mck_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mck_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    output logic [Width-1:0]         o_rdata_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_b
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata_a;
    logic [Width-1:0] r_rdata_b;

    // Write, then read both ports through registers
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/core/mck_seq.sv -----
// Element sequencer: takes a character and walks its pattern, one request a cycle while the output stage can take it.
// Depends on mck_pkg.
module mck_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [mck_pkg::CharW-1:0] i_char,
    output logic                      o_ready,
    input  logic                      i_can_issue,
    output logic                      o_issue,
    output mck_pkg::t_req             o_req
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TONE = 4'b0010,
        S_GAP  = 4'b0100,
        S_WORD = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [mck_pkg::PatW-1:0]   r_pat, n_pat;
    logic [mck_pkg::IdxW-1:0]   char_idx;
    logic                       pat_end;

    assign o_ready = (r_state == S_IDLE);
    assign pat_end = (r_pat[mck_pkg::PatW-1:1] == '0);
    assign o_issue = (r_state != S_IDLE) && i_can_issue;

    // Map a character to its table slot, unknown ones to the query mark
    always_comb begin
        if (i_char < mck_pkg::CharFirst || i_char > mck_pkg::CharLast) begin
            char_idx = mck_pkg::IdxW'(mck_pkg::CharQuery - mck_pkg::CharFirst);
        end else begin
            char_idx = mck_pkg::IdxW'(i_char - mck_pkg::CharFirst);
        end
    end

    // Request for the current step
    always_comb begin
        o_req = '{tone: 1'b0, last: 1'b0, reg_sel: mck_pkg::REG_ELEM_GAP};
        unique case (r_state)
            S_TONE: begin
                if (pat_end) begin
                    o_req = '{tone: 1'b0, last: 1'b1, reg_sel: mck_pkg::REG_LETTER_GAP};
                end else begin
                    o_req = '{tone: 1'b1, last: 1'b0,
                              reg_sel: r_pat[0] ? mck_pkg::REG_DASH : mck_pkg::REG_DOT};
                end
            end
            S_WORD: o_req = '{tone: 1'b0, last: 1'b1, reg_sel: mck_pkg::REG_WORD_GAP};
            default: o_req = '{tone: 1'b0, last: 1'b0, reg_sel: mck_pkg::REG_ELEM_GAP};
        endcase
    end

    // Advance through the pattern on each issued request
    always_comb begin
        n_state = r_state;
        n_pat   = r_pat;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_char == mck_pkg::CharSpace) begin
                        n_state = S_WORD;
                    end else begin
                        n_state = S_TONE;
                        n_pat   = mck_pkg::code_pattern(char_idx);
                    end
                end
            end
            S_TONE: begin
                if (i_can_issue) begin
                    n_state = pat_end ? S_IDLE : S_GAP;
                end
            end
            S_GAP: begin
                if (i_can_issue) begin
                    n_state = S_TONE;
                    n_pat   = r_pat >> 1;
                end
            end
            S_WORD: begin
                if (i_can_issue) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pat <= n_pat;
    end

endmodule

// ----- rtl/core/mck_out.sv -----
// Output stage: collects read data for issued requests into a two-entry buffer.
// Depends on mck_pkg.
module mck_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_issue,
    input  mck_pkg::t_req             i_req,
    input  logic [mck_pkg::DurW-1:0]  i_rdata,
    input  logic [mck_pkg::NumRegs-1:0] i_reg_valid,
    output logic                      o_can_issue,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mck_pkg::t_elem            o_elem
);

    logic                      r_inflight;
    mck_pkg::t_req             r_if_req;
    mck_pkg::t_elem            r_buf [2];
    logic                      r_wp, r_rp;
    logic [1:0]                r_cnt;
    logic                      pop;
    logic [2:0]                occ_next;
    logic [mck_pkg::DurW-1:0]  dur;

    assign pop         = o_valid && i_ready;
    assign o_valid     = (r_cnt != 2'd0);
    assign o_elem      = r_buf[r_rp];
    assign occ_next    = {1'b0, r_cnt} + 3'(r_inflight) - 3'(pop);
    assign o_can_issue = (occ_next < 3'd2);

    // Unwritten registers read as their reset value
    assign dur = i_reg_valid[r_if_req.reg_sel] ? i_rdata
                                               : mck_pkg::reg_reset(r_if_req.reg_sel);

    // Track the read in flight and the buffer pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_inflight <= i_issue;
            if (r_inflight) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(occ_next);
        end
        if (i_issue) begin
            r_if_req <= i_req;
        end
        if (r_inflight) begin
            r_buf[r_wp] <= '{tone: r_if_req.tone, dur: dur, last: r_if_req.last};
        end
    end

endmodule

// ----- rtl/core/morse_character_keyer.sv -----
// Morse character keyer top level: stream ports, APB register port, register memory.
// Depends on mck_pkg, mck_ram, mck_seq and mck_out.
//
// Each accepted character gives a run of keying elements on the master stream:
// one silent word gap for a space, otherwise a tone and an element gap per dot or
// dash followed by a letter gap (up to 13 elements); unknown characters are sent
// as '?'. Durations come from five 8-bit registers kept in a small RAM and read
// one element per cycle, while the output buffer has room, through its single
// keyer read port. A taken character is registered into the sequencer state,
// each request with its read data, then written to the output buffer; the next
// character is taken the cycle after the last read is issued, and a run is
// stretched by any stall on the master side. The output holds two elements, so
// the keyer keeps reading while a finished element waits. Registers at byte
// addresses 0,4,8,12,16: dot, dash, element gap, letter gap, word gap (bits 7:0).
module morse_character_keyer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream: tdata = char_code[7:0]
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [mck_pkg::CharW-1:0]   i_s_axis_tdata,
    // master stream: tdata = duration_units[7:0]; tuser = tone_on
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [mck_pkg::DurW-1:0]    o_m_axis_tdata,
    output logic                        o_m_axis_tuser,
    output logic                        o_m_axis_tlast,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mck_pkg::PaddrW-1:0]  paddr,
    input  logic [mck_pkg::ApbDw-1:0]   pwdata,
    output logic [mck_pkg::ApbDw-1:0]   prdata,
    output logic                        pready
);

    logic [mck_pkg::NumRegs-1:0]  r_reg_valid;
    logic [mck_pkg::RegAw-1:0]    r_rd_idx;
    logic                         r_rd_hit;
    logic [mck_pkg::RegAw-1:0]    apb_idx;
    logic                         apb_hit;
    logic                         cfg_we;
    logic [mck_pkg::RegAw-1:0]    rd_addr_b;
    logic [mck_pkg::DurW-1:0]     rdata_a, rdata_b, rd_val;
    logic                         can_issue, issue;
    mck_pkg::t_req                req;
    mck_pkg::t_elem               elem;

    // Decode the register port
    assign pready    = 1'b1;
    assign apb_idx   = paddr[mck_pkg::PaddrW-1:2];
    assign apb_hit   = (apb_idx < mck_pkg::RegAw'(mck_pkg::NumRegs));
    assign cfg_we    = psel && penable && pwrite && pready && apb_hit;
    assign rd_addr_b = apb_hit ? apb_idx : '0;

    mck_ram #(
        .Width (mck_pkg::DurW),
        .Depth (mck_pkg::NumRegs)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (cfg_we),
        .i_waddr   (apb_idx),
        .i_wdata   (pwdata[mck_pkg::DurW-1:0]),
        .i_raddr_a (req.reg_sel),
        .o_rdata_a (rdata_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_b (rdata_b)
    );

    // Mark registers once written; capture the read address for prdata
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid <= '0;
        end else if (cfg_we) begin
            r_reg_valid[apb_idx] <= 1'b1;
        end
        r_rd_idx <= rd_addr_b;
        r_rd_hit <= apb_hit;
    end

    assign rd_val = r_reg_valid[r_rd_idx] ? rdata_b
                                          : mck_pkg::reg_reset(mck_pkg::t_reg'(r_rd_idx));
    assign prdata = r_rd_hit ? mck_pkg::ApbDw'(rd_val) : '0;

    mck_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_char      (i_s_axis_tdata),
        .o_ready     (o_s_axis_tready),
        .i_can_issue (can_issue),
        .o_issue     (issue),
        .o_req       (req)
    );

    mck_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_req       (req),
        .i_rdata     (rdata_a),
        .i_reg_valid (r_reg_valid),
        .o_can_issue (can_issue),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_elem      (elem)
    );

    assign o_m_axis_tdata = elem.dur;
    assign o_m_axis_tuser = elem.tone;
    assign o_m_axis_tlast = elem.last;

endmodule

// ----- rtl/core/mck_chk.sv -----
// Port-level checker for the Morse character keyer, bound to the top level.
// Depends on mck_pkg and morse_character_keyer.
module mck_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [mck_pkg::DurW-1:0]    o_m_axis_tdata,
    input logic                        o_m_axis_tuser,
    input logic                        o_m_axis_tlast,
    input logic [mck_pkg::ApbDw-1:0]   prdata
);

    // A run never closes on a tone
    a_tone_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> !o_m_axis_tlast)
        else $error("tone element marked last");

    // One character at a time: the slave side closes after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second character taken while one is in progress");

    // Registers are eight bits wide
    a_prdata_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[mck_pkg::ApbDw-1:mck_pkg::DurW] == '0)
        else $error("register read returns bits above the register width");

    // Hold a stalled element
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled element changed");

endmodule

bind morse_character_keyer mck_chk u_mck_chk (.*);

// ----- test/mck_checker.sv -----
// Scoreboard for the Morse character keyer: follows register writes, predicts keying runs.
// Watches both stream channels and the register port; depends on mck_pkg only.
module mck_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream: tdata = char_code[7:0]
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [mck_pkg::CharW-1:0]          i_s_tdata,
    // master stream: tdata = duration_units[7:0]; tuser = tone_on
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [mck_pkg::DurW-1:0]           i_m_tdata,
    input  logic                               i_m_tuser,
    input  logic                               i_m_tlast,
    // register port
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [mck_pkg::PaddrW-1:0]         i_paddr,
    input  logic [mck_pkg::ApbDw-1:0]          i_pwdata,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Patterns from '0' to 'Z': LSB first, 1 is a dash, the top set bit only ends the run
    localparam logic [7:0] MORSE_CODES [43] = '{
        8'h3f, 8'h3e, 8'h3c, 8'h38, 8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2f, 8'h47,
        8'h55, 8'h2d, 8'h31, 8'h6d, 8'h4c, 8'h56, 8'h06, 8'h11, 8'h15, 8'h09, 8'h02,
        8'h14, 8'h0b, 8'h10, 8'h04, 8'h1e, 8'h0d, 8'h12, 8'h07, 8'h05, 8'h0f, 8'h16,
        8'h1b, 8'h0a, 8'h08, 8'h03, 8'h0c, 8'h18, 8'h0e, 8'h19, 8'h1d, 8'h13
    };

    logic [mck_pkg::DurW-1:0] unit_regs [mck_pkg::NumRegs];
    mck_pkg::t_elem           expected_elems [$];
    int                       err_cnt = 0;
    int                       checked_cnt = 0;

    function automatic void push_elem(input logic tone, input logic [mck_pkg::DurW-1:0] dur,
                                      input logic last);
        mck_pkg::t_elem e;
        e.tone = tone;
        e.dur  = dur;
        e.last = last;
        expected_elems.push_back(e);
    endfunction

    // Queue the keying run that one character should produce
    function automatic void queue_run(input logic [mck_pkg::CharW-1:0] ch_in);
        logic [mck_pkg::CharW-1:0] ch;
        logic [7:0]                pat;
        logic                      is_dash;
        ch = ch_in;
        if (ch == mck_pkg::CharSpace) begin
            push_elem(1'b0, unit_regs[mck_pkg::REG_WORD_GAP], 1'b1);
            return;
        end
        if (ch < mck_pkg::CharFirst || ch > mck_pkg::CharLast)
            ch = mck_pkg::CharQuery;
        pat = MORSE_CODES[mck_pkg::IdxW'(ch - mck_pkg::CharFirst)];
        while (pat > 8'h01) begin
            is_dash = pat[0];
            pat     = pat >> 1;
            push_elem(1'b1, is_dash ? unit_regs[mck_pkg::REG_DASH]
                                    : unit_regs[mck_pkg::REG_DOT], 1'b0);
            push_elem(1'b0, unit_regs[mck_pkg::REG_ELEM_GAP], 1'b0);
        end
        push_elem(1'b0, unit_regs[mck_pkg::REG_LETTER_GAP], 1'b1);
    endfunction

    always @(posedge i_clk) begin
        mck_pkg::t_elem             want;
        logic [mck_pkg::RegAw-1:0]  reg_idx;
        if (!i_rst_n) begin
            expected_elems.delete();
            unit_regs[mck_pkg::REG_DOT]        = 8'd1;
            unit_regs[mck_pkg::REG_DASH]       = 8'd3;
            unit_regs[mck_pkg::REG_ELEM_GAP]   = 8'd1;
            unit_regs[mck_pkg::REG_LETTER_GAP] = 8'd3;
            unit_regs[mck_pkg::REG_WORD_GAP]   = 8'd7;
        end else begin
            // Track register writes; unmapped indexes change nothing
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr[mck_pkg::PaddrW-1:2];
                unique case (reg_idx)
                    mck_pkg::REG_DOT, mck_pkg::REG_DASH, mck_pkg::REG_ELEM_GAP,
                    mck_pkg::REG_LETTER_GAP, mck_pkg::REG_WORD_GAP: begin
                        unit_regs[reg_idx] = i_pwdata[mck_pkg::DurW-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                queue_run(i_s_tdata);
            // Compare each delivered element with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                if (expected_elems.size() == 0) begin
                    if (err_cnt < 10)
                        $display("%0t: unexpected element tone=%0b dur=%0d last=%0b",
                                 $realtime, i_m_tuser, i_m_tdata, i_m_tlast);
                    err_cnt++;
                end else begin
                    want = expected_elems.pop_front();
                    checked_cnt++;
                    if (want.tone !== i_m_tuser || want.dur !== i_m_tdata
                            || want.last !== i_m_tlast) begin
                        if (err_cnt < 10)
                            $display("%0t: element %0d expected tone=%0b dur=%0d last=%0b,",
                                     $realtime, checked_cnt, want.tone, want.dur, want.last,
                                     " got tone=%0b dur=%0d last=%0b",
                                     i_m_tuser, i_m_tdata, i_m_tlast);
                        err_cnt++;
                    end
                end
            end
        end
        o_errors  <= err_cnt;
        o_checked <= checked_cnt;
        o_pending <= expected_elems.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the keyer testbench: clock, reset, character stimulus, register settings, verdict.
// Depends on mck_pkg, morse_character_keyer and mck_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the map; writes there must be ignored
    localparam logic [mck_pkg::RegAw-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [mck_pkg::RegAw-1:0] REG_SPARE_HI = 3'd7;
    localparam int RAND_PER_PHASE = 75;
    localparam int NUM_PHASES     = 6;
    localparam int LONG_HOLD      = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_valid = 1'b0;
    logic [mck_pkg::CharW-1:0]  s_data = '0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [mck_pkg::DurW-1:0]   m_data;
    logic                       m_user;
    logic                       m_last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [mck_pkg::PaddrW-1:0] paddr = '0;
    logic [mck_pkg::ApbDw-1:0]  pwdata = '0;
    logic [mck_pkg::ApbDw-1:0]  prdata;
    logic                       pready;

    int   errors;
    int   pending;
    int   checked;
    int   chars_sent = 0;
    int   settings_run = 1;
    logic idle_en = 1'b1;
    logic long_hold_req = 1'b0;
    int   stall_left = 0;

    morse_character_keyer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    mck_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .i_m_tlast  (m_last),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when idling is off
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [mck_pkg::RegAw-1:0] idx,
                             input logic [mck_pkg::DurW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'($urandom_range(0, 255)), 16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_units(input logic [mck_pkg::DurW-1:0] dot,
                             input logic [mck_pkg::DurW-1:0] dash,
                             input logic [mck_pkg::DurW-1:0] egap,
                             input logic [mck_pkg::DurW-1:0] lgap,
                             input logic [mck_pkg::DurW-1:0] wgap);
        reg_write(mck_pkg::REG_DOT, dot);
        reg_write(mck_pkg::REG_DASH, dash);
        reg_write(mck_pkg::REG_ELEM_GAP, egap);
        reg_write(mck_pkg::REG_LETTER_GAP, lgap);
        reg_write(mck_pkg::REG_WORD_GAP, wgap);
        settings_run++;
    endtask

    // Offer one character, with an optional idle burst first, and hold until transfer
    task automatic send_char(input logic [mck_pkg::CharW-1:0] ch);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= ch;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    // Drop valid, wait for every expected element, then let the keyer settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Mostly table characters, some spaces, the rest anything in the byte range
    function automatic logic [mck_pkg::CharW-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return mck_pkg::CharFirst + mck_pkg::CharW'($urandom_range(0, 42));
        else if (r < 85)
            return mck_pkg::CharSpace;
        return mck_pkg::CharW'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [mck_pkg::CharW-1:0] directed [$];
        directed = '{8'h00, 8'hFF, mck_pkg::CharSpace, mck_pkg::CharFirst, 8'h39, 8'h3A,
                     8'h3B, 8'h3E, mck_pkg::CharQuery, 8'h40, 8'h41, 8'h45, 8'h54,
                     mck_pkg::CharLast, 8'h5B, 8'h2F, 8'h61, 8'h7F, 8'h80, 8'h21,
                     mck_pkg::CharSpace, 8'h4B};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed characters under reset values
        foreach (directed[i])
            send_char(directed[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            unique case (p)
                0: set_units(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                1: begin
                    set_units(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                    reg_write(REG_SPARE_LO, 8'hA5);
                    reg_write(REG_SPARE_HI, 8'h5A);
                end
                2: set_units(8'd1, 8'd255, 8'd0, 8'd255, 8'd1);
                default: set_units(mck_pkg::DurW'($urandom_range(0, 255)),
                                   mck_pkg::DurW'($urandom_range(0, 255)),
                                   mck_pkg::DurW'($urandom_range(0, 255)),
                                   mck_pkg::DurW'($urandom_range(0, 255)),
                                   mck_pkg::DurW'($urandom_range(0, 255)));
            endcase
            idle_en = (p != NUM_PHASES - 1);
            // Back-pressure hard enough to fill the output and stall the input
            if (p == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_char(pick_char());
            drain();
        end

        repeat (40) @(posedge i_clk);
        $display("Sent %0d characters under %0d register settings; %0d elements checked.",
                 chars_sent, settings_run, checked);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mck_pkg.sv
rtl/core/mck_ram.sv
rtl/core/mck_seq.sv
rtl/core/mck_out.sv
rtl/core/morse_character_keyer.sv
rtl/core/mck_chk.sv
test/mck_checker.sv
test/tb_top.sv
